/* rtl/core/plac_pkg.sv */
`default_nettype none

package plac_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int ACC_WIDTH  = 64;
  localparam int WORD_WIDTH = 64;
  localparam int LOG_ITERS  = 30;
  localparam int CFG_WIDTH  = 32;
  localparam int DIV_WIDTH  = WORD_WIDTH + FRAC_BITS;

  typedef logic signed [WORD_WIDTH-1:0] word_t;

  localparam word_t WORD_MAX   = {1'b0, {(WORD_WIDTH-1){1'b1}}};
  localparam word_t WORD_MIN   = {1'b1, {(WORD_WIDTH-1){1'b0}}};
  localparam word_t ONE        = word_t'(64'sd1 <<< FRAC_BITS);
  localparam word_t LN2_Q30    = 64'sd744261118;
  localparam word_t TWO_PI_Q30 = 64'sd6746518852;

  typedef enum logic [1:0] {
    MODE_XENT  = 2'd0,
    MODE_GAUSS = 2'd1,
    MODE_BRIER = 2'd2,
    MODE_HINGE = 2'd3
  } loss_mode_t;

  typedef enum logic [1:0] {
    REG_LOSS_MODE = 2'd0,
    REG_CLAMP_TOL = 2'd1,
    REG_SIGMA     = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    UOP_MUL = 2'd0,
    UOP_LOG = 2'd1,
    UOP_DIV = 2'd2
  } uop_kind_t;

  typedef enum logic [3:0] {
    SRC_P, SRC_T, SRC_PC, SRC_OMPC, SRC_OMT, SRC_D, SRC_SIGMA,
    SRC_LN2, SRC_TWO_PI, SRC_RA, SRC_RB, SRC_RS, SRC_RY
  } src_t;

  typedef enum logic [1:0] {
    DST_RA, DST_RB, DST_RS, DST_RY
  } dst_t;

  typedef enum logic [1:0] {
    SH_FRAC, SH_Q30, SH_LN
  } shift_t;

  typedef struct packed {
    uop_kind_t kind;
    src_t      a;
    src_t      b;
    shift_t    sh;
    dst_t      dst;
    logic      last;
  } uop_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ISSUE, ST_WAIT, ST_FINISH, ST_ACCUM
  } ctrl_state_t;

  typedef enum logic [1:0] {
    LOG_IDLE, LOG_NORM, LOG_ITER
  } log_phase_t;

  typedef struct packed {
    logic load;
    logic start;
    uop_t uop;
    logic finish;
    logic accum;
  } dp_cmd_t;

  typedef struct packed {
    logic       done;
    logic       last;
    logic       out_valid;
    loss_mode_t mode;
  } dp_stat_t;

  function automatic uop_t mk(uop_kind_t k, src_t a, src_t b, shift_t sh, dst_t d,
                              logic last);
    uop_t u;
    u.kind = k;
    u.a    = a;
    u.b    = b;
    u.sh   = sh;
    u.dst  = d;
    u.last = last;
    return u;
  endfunction

  // Per-mode micro-op sequence.
  function automatic uop_t uop_lookup(loss_mode_t mode, logic [2:0] idx);
    uop_t u;
    u = mk(UOP_MUL, SRC_D, SRC_D, SH_FRAC, DST_RA, 1'b1);
    case (mode)
      MODE_XENT: begin
        case (idx)
          3'd0: u = mk(UOP_LOG, SRC_PC, SRC_PC, SH_FRAC, DST_RY, 1'b0);
          3'd1: u = mk(UOP_MUL, SRC_RY, SRC_LN2, SH_LN, DST_RA, 1'b0);
          3'd2: u = mk(UOP_MUL, SRC_T, SRC_RA, SH_FRAC, DST_RA, 1'b0);
          3'd3: u = mk(UOP_LOG, SRC_OMPC, SRC_OMPC, SH_FRAC, DST_RY, 1'b0);
          3'd4: u = mk(UOP_MUL, SRC_RY, SRC_LN2, SH_LN, DST_RB, 1'b0);
          default: u = mk(UOP_MUL, SRC_OMT, SRC_RB, SH_FRAC, DST_RB, 1'b1);
        endcase
      end
      MODE_GAUSS: begin
        case (idx)
          3'd0: u = mk(UOP_MUL, SRC_SIGMA, SRC_SIGMA, SH_FRAC, DST_RS, 1'b0);
          3'd1: u = mk(UOP_MUL, SRC_D, SRC_D, SH_FRAC, DST_RA, 1'b0);
          3'd2: u = mk(UOP_DIV, SRC_RA, SRC_RS, SH_FRAC, DST_RA, 1'b0);
          3'd3: u = mk(UOP_MUL, SRC_RS, SRC_TWO_PI, SH_Q30, DST_RB, 1'b0);
          3'd4: u = mk(UOP_LOG, SRC_RB, SRC_RB, SH_FRAC, DST_RY, 1'b0);
          default: u = mk(UOP_MUL, SRC_RY, SRC_LN2, SH_LN, DST_RB, 1'b1);
        endcase
      end
      MODE_BRIER: u = mk(UOP_MUL, SRC_D, SRC_D, SH_FRAC, DST_RA, 1'b1);
      default:    u = mk(UOP_MUL, SRC_T, SRC_P, SH_FRAC, DST_RA, 1'b1);
    endcase
    return u;
  endfunction

  function automatic word_t add_sat(word_t a, word_t b);
    logic signed [WORD_WIDTH:0] s;
    s = {a[WORD_WIDTH-1], a} + {b[WORD_WIDTH-1], b};
    if (s[WORD_WIDTH] != s[WORD_WIDTH-1]) begin
      return s[WORD_WIDTH] ? WORD_MIN : WORD_MAX;
    end
    return s[WORD_WIDTH-1:0];
  endfunction

  function automatic word_t neg_sat(word_t a);
    return (a == WORD_MIN) ? WORD_MAX : -a;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/plac_ifs.sv */
`default_nettype none

interface plac_item_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [plac_pkg::DATA_WIDTH-1:0] predicted;
  logic signed [plac_pkg::DATA_WIDTH-1:0] target;
  logic                                   last_element;
  modport source (output valid, predicted, target, last_element, input ready);
  modport sink (input valid, predicted, target, last_element, output ready);
endinterface

interface plac_result_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] loss_sum;
  logic               saturated;
  modport source (output valid, loss_sum, saturated, input ready);
  modport sink (input valid, loss_sum, saturated, output ready);
endinterface

interface plac_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         index;
  logic [plac_pkg::CFG_WIDTH-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/core/probabilistic_loss_accumulator.sv */
// Probabilistic loss accumulator (binary cross entropy and friends).
// Channels: item (predicted and target in signed Q16.16, last_element),
// result (loss_sum in signed Q48.16 and a sticky saturated flag) and cfg
// (index 0 loss_mode, 1 clamp_tolerance, 2 sigma; other indexes dropped).
// Each beat on item adds one per-element loss to the running sum; a beat
// with last_element set produces one result beat and clears the sum.
// Items are processed one at a time: a new item is taken only in the idle
// state, after the previous item has run its micro-ops, its combine step
// and its accumulate step. Brier and hinge run one multiply, cross entropy
// two logs and four multiplies, and gaussian a bit-serial divide, one log
// and four multiplies. The result beat is registered in the accumulate step
// of the item that ends the vector. The result waits in an output register,
// so the next item is taken while it is unclaimed; an item that ends a
// further vector holds in the accumulate step, and no new item is taken,
// until the receiver takes the pending beat.
// Reset (synchronous) restores the default registers, clears the sum and
// the flag and empties the output register; no clearing pass is needed.
// Write cfg only while no item is in flight.
`default_nettype none

module probabilistic_loss_accumulator (
  input  logic          clk,
  input  logic          rst,
  plac_cfg_if.sink      cfg,
  plac_item_if.sink     item,
  plac_result_if.source result
);

  plac_pkg::dp_cmd_t  cmd;
  plac_pkg::dp_stat_t stat;

  // Sequence the micro-ops for each element.
  plac_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // Hold operands, run the arithmetic units, accumulate and drive results.
  plac_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .predicted    (item.predicted),
    .target       (item.target),
    .last_element (item.last_element),
    .cfg          (cfg),
    .result       (result)
  );

endmodule

`default_nettype wire

/* rtl/core/plac_mul.sv */
`default_nettype none

// Signed 64x64 multiply with right shift, built from four 32x32 partial
// products; magnitude truncation and saturation to 64 bits.
module plac_mul (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  plac_pkg::word_t  a,
  input  plac_pkg::word_t  b,
  input  plac_pkg::shift_t sh,
  output logic             done,
  output plac_pkg::word_t  res
);

  logic [2:0]   step;
  logic         busy;
  logic         neg;
  logic [63:0]  ua;
  logic [63:0]  ub;
  logic [63:0]  pp;
  logic [6:0]   pp_off;
  logic [6:0]   pp_off_next;
  logic [127:0] acc;
  logic [6:0]   shamt;
  logic [31:0]  opx;
  logic [31:0]  opy;
  logic [127:0] r;
  plac_pkg::word_t fin;

  always_comb begin
    case (step)
      3'd0: begin
        opx = ua[31:0];
        opy = ub[31:0];
        pp_off_next = 7'd0;
      end
      3'd1: begin
        opx = ua[31:0];
        opy = ub[63:32];
        pp_off_next = 7'd32;
      end
      3'd2: begin
        opx = ua[63:32];
        opy = ub[31:0];
        pp_off_next = 7'd32;
      end
      default: begin
        opx = ua[63:32];
        opy = ub[63:32];
        pp_off_next = 7'd64;
      end
    endcase
  end

  always_comb begin
    r = acc >> shamt;
    if (neg) begin
      if (r[127:64] != 64'd0 || r[63:0] > 64'h8000_0000_0000_0000) begin
        fin = plac_pkg::WORD_MIN;
      end else begin
        fin = plac_pkg::word_t'(64'd0 - r[63:0]);
      end
    end else begin
      if (r[127:63] != 65'd0) begin
        fin = plac_pkg::WORD_MAX;
      end else begin
        fin = plac_pkg::word_t'(r[63:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= 3'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= 3'd0;
        neg  <= a[63] ^ b[63];
        ua   <= a[63] ? 64'(-a) : 64'(a);
        ub   <= b[63] ? 64'(-b) : 64'(b);
        acc  <= 128'd0;
        case (sh)
          plac_pkg::SH_Q30: shamt <= 7'd30;
          plac_pkg::SH_LN:  shamt <= 7'(60 - plac_pkg::FRAC_BITS);
          default:          shamt <= 7'(plac_pkg::FRAC_BITS);
        endcase
      end else if (busy) begin
        step <= step + 3'd1;
        if (step < 3'd4) begin
          pp     <= {32'd0, opx} * {32'd0, opy};
          pp_off <= pp_off_next;
        end
        if (step >= 3'd1 && step <= 3'd4) begin
          acc <= acc + ({64'd0, pp} << pp_off);
        end
        if (step == 3'd5) begin
          res  <= fin;
          done <= 1'b1;
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/plac_log.sv */
`default_nettype none

// Base-2 log in Q.30 with integer part: normalize in six halving steps,
// then one squaring step per fraction bit.
module plac_log (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  plac_pkg::word_t x,
  output logic            done,
  output plac_pkg::word_t y
);

  plac_pkg::log_phase_t phase;
  logic [63:0] n;
  logic [5:0]  cnt;
  logic [4:0]  idx;
  logic [30:0] m;
  logic [29:0] frac;
  logic [6:0]  k;
  logic [61:0] sq;
  logic [31:0] m2;
  logic signed [6:0] ex;

  always_comb begin
    case (idx[2:0])
      3'd0:    k = 7'd32;
      3'd1:    k = 7'd16;
      3'd2:    k = 7'd8;
      3'd3:    k = 7'd4;
      3'd4:    k = 7'd2;
      default: k = 7'd1;
    endcase
    sq = {31'd0, m} * {31'd0, m};
    m2 = sq[61:30];
    ex = 7'(63 - plac_pkg::FRAC_BITS) - {1'b0, cnt};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= plac_pkg::LOG_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (phase)
        plac_pkg::LOG_IDLE: begin
          if (start) begin
            n     <= (x < 64'sd1) ? 64'd1 : 64'(x);
            cnt   <= 6'd0;
            idx   <= 5'd0;
            phase <= plac_pkg::LOG_NORM;
          end
        end
        plac_pkg::LOG_NORM: begin
          if ((n >> (7'd64 - k)) == 64'd0) begin
            n   <= n << k;
            cnt <= cnt + k[5:0];
          end
          idx <= idx + 5'd1;
          if (idx == 5'd5) begin
            idx   <= 5'd0;
            phase <= plac_pkg::LOG_ITER;
          end
        end
        plac_pkg::LOG_ITER: begin
          if (idx == 5'd0) begin
            m <= n[63:33];
            idx <= 5'd1;
          end else begin
            if (m2[31]) begin
              m    <= m2[31:1];
              frac <= {frac[28:0], 1'b1};
            end else begin
              m    <= m2[30:0];
              frac <= {frac[28:0], 1'b0};
            end
            idx <= idx + 5'd1;
            if (idx == 5'(plac_pkg::LOG_ITERS)) begin
              phase <= plac_pkg::LOG_IDLE;
              done  <= 1'b1;
            end
          end
        end
        default: phase <= plac_pkg::LOG_IDLE;
      endcase
    end
  end

  assign y = {{27{ex[6]}}, ex, frac};

endmodule

`default_nettype wire

/* rtl/core/plac_dp.sv */
`default_nettype none

// Datapath: configuration, operand registers, the shared multiply, log and
// divide units, loss combine and the saturating accumulator.
module plac_dp (
  input  logic                                   clk,
  input  logic                                   rst,
  input  plac_pkg::dp_cmd_t                      cmd,
  output plac_pkg::dp_stat_t                     stat,
  input  logic signed [plac_pkg::DATA_WIDTH-1:0] predicted,
  input  logic signed [plac_pkg::DATA_WIDTH-1:0] target,
  input  logic                                   last_element,
  plac_cfg_if.sink                               cfg,
  plac_result_if.source                          result
);

  plac_pkg::loss_mode_t mode;
  logic [14:0] tol;
  logic [30:0] sigma;

  plac_pkg::word_t rp, rt, rpc, rompc, romt, rd;
  plac_pkg::word_t ra, rb, rs, ry, rv;
  logic            last_r;
  logic signed [plac_pkg::ACC_WIDTH-1:0] acc;
  logic            sat_seen;

  plac_pkg::word_t p_in, t_in, lo, hi, p1, pc;
  plac_pkg::word_t opa, opb;
  plac_pkg::word_t mul_res, log_res, div_res, unit_res, v;
  logic            mul_done, log_done, div_done;
  plac_pkg::uop_kind_t kind_r;
  plac_pkg::dst_t      dst_r;

  // Restoring divider state.
  logic                              dv_busy;
  logic                              dv_done;
  logic [6:0]                        dv_cnt;
  logic [63:0]                       dv_rem;
  logic [63:0]                       dv_b;
  logic [plac_pkg::DIV_WIDTH-1:0]    dv_num;
  logic [plac_pkg::DIV_WIDTH-1:0]    dv_q;
  logic [64:0]                       dv_rem2;
  logic                              dv_bit;

  localparam logic signed [plac_pkg::ACC_WIDTH:0] AMAX =
    {2'b00, {(plac_pkg::ACC_WIDTH-1){1'b1}}};
  localparam logic signed [plac_pkg::ACC_WIDTH:0] AMIN =
    {2'b11, {(plac_pkg::ACC_WIDTH-1){1'b0}}};

  logic signed [plac_pkg::ACC_WIDTH:0]   sum;
  logic signed [plac_pkg::ACC_WIDTH-1:0] acc_next;
  logic                                  sat_next;
  plac_pkg::word_t hq, hl, hs;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= plac_pkg::MODE_XENT;
      tol   <= 15'd1;
      sigma <= 31'd65536;
    end else if (cfg.valid) begin
      case (cfg.index)
        plac_pkg::REG_LOSS_MODE: mode  <= plac_pkg::loss_mode_t'(cfg.data[1:0]);
        plac_pkg::REG_CLAMP_TOL: tol   <= cfg.data[14:0];
        plac_pkg::REG_SIGMA:     sigma <= cfg.data[30:0];
        default: ;
      endcase
    end
  end

  // Clamp for cross entropy; the low bound wins when the bounds cross.
  always_comb begin
    p_in = plac_pkg::word_t'(predicted);
    t_in = plac_pkg::word_t'(target);
    lo   = plac_pkg::word_t'({1'b0, tol});
    hi   = plac_pkg::ONE - lo;
    p1   = (p_in > hi) ? hi : p_in;
    pc   = (p1 < lo) ? lo : p1;
  end

  always_comb begin
    case (cmd.uop.a)
      plac_pkg::SRC_P:      opa = rp;
      plac_pkg::SRC_T:      opa = rt;
      plac_pkg::SRC_PC:     opa = rpc;
      plac_pkg::SRC_OMPC:   opa = rompc;
      plac_pkg::SRC_OMT:    opa = romt;
      plac_pkg::SRC_D:      opa = rd;
      plac_pkg::SRC_SIGMA:  opa = plac_pkg::word_t'({1'b0, sigma});
      plac_pkg::SRC_RA:     opa = ra;
      plac_pkg::SRC_RB:     opa = rb;
      plac_pkg::SRC_RS:     opa = rs;
      plac_pkg::SRC_RY:     opa = ry;
      default:              opa = rp;
    endcase
    case (cmd.uop.b)
      plac_pkg::SRC_P:      opb = rp;
      plac_pkg::SRC_T:      opb = rt;
      plac_pkg::SRC_D:      opb = rd;
      plac_pkg::SRC_SIGMA:  opb = plac_pkg::word_t'({1'b0, sigma});
      plac_pkg::SRC_LN2:    opb = plac_pkg::LN2_Q30;
      plac_pkg::SRC_TWO_PI: opb = plac_pkg::TWO_PI_Q30;
      plac_pkg::SRC_RA:     opb = ra;
      plac_pkg::SRC_RB:     opb = rb;
      plac_pkg::SRC_RS:     opb = rs;
      default:              opb = rb;
    endcase
  end

  plac_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.start && cmd.uop.kind == plac_pkg::UOP_MUL),
    .a     (opa),
    .b     (opb),
    .sh    (cmd.uop.sh),
    .done  (mul_done),
    .res   (mul_res)
  );

  plac_log u_log (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.start && cmd.uop.kind == plac_pkg::UOP_LOG),
    .x     (opa),
    .done  (log_done),
    .y     (log_res)
  );

  // Long division of (a << FRAC_BITS) by b, one quotient bit per cycle.
  always_comb begin
    dv_rem2 = {dv_rem, dv_num[plac_pkg::DIV_WIDTH-1]};
    dv_bit  = (dv_rem2 >= {1'b0, dv_b});
    div_res = (dv_q[plac_pkg::DIV_WIDTH-1:63] != '0) ? plac_pkg::WORD_MAX :
              plac_pkg::word_t'(dv_q[63:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_busy <= 1'b0;
      dv_done <= 1'b0;
    end else begin
      dv_done <= 1'b0;
      if (cmd.start && cmd.uop.kind == plac_pkg::UOP_DIV) begin
        dv_busy <= 1'b1;
        dv_cnt  <= 7'd0;
        dv_rem  <= 64'd0;
        dv_b    <= 64'(opb);
        dv_num  <= {64'(opa), {plac_pkg::FRAC_BITS{1'b0}}};
        dv_q    <= '0;
      end else if (dv_busy) begin
        dv_rem  <= dv_bit ? 64'(dv_rem2 - {1'b0, dv_b}) : dv_rem2[63:0];
        dv_num  <= dv_num << 1;
        dv_q    <= {dv_q[plac_pkg::DIV_WIDTH-2:0], dv_bit};
        dv_cnt  <= dv_cnt + 7'd1;
        if (dv_cnt == 7'(plac_pkg::DIV_WIDTH - 1)) begin
          dv_busy <= 1'b0;
          dv_done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    case (kind_r)
      plac_pkg::UOP_LOG: begin
        stat.done = log_done;
        unit_res  = log_res;
      end
      plac_pkg::UOP_DIV: begin
        stat.done = dv_done;
        unit_res  = div_res;
      end
      default: begin
        stat.done = mul_done;
        unit_res  = mul_res;
      end
    endcase
    stat.last      = last_r;
    stat.out_valid = result.valid;
    stat.mode      = mode;
  end

  // Combine the partial results of the element into its loss.
  always_comb begin
    hq = ra >>> 1;
    hl = rb / 64'sd2;
    hs = plac_pkg::add_sat(plac_pkg::ONE, plac_pkg::neg_sat(ra));
    case (mode)
      plac_pkg::MODE_XENT:  v = plac_pkg::neg_sat(plac_pkg::add_sat(ra, rb));
      plac_pkg::MODE_GAUSS: v = plac_pkg::add_sat(-hq, -hl);
      plac_pkg::MODE_BRIER: v = ra;
      default:              v = (hs < 64'sd0) ? 64'sd0 : hs;
    endcase
  end

  always_comb begin
    sum = {acc[plac_pkg::ACC_WIDTH-1], acc} +
          (plac_pkg::ACC_WIDTH+1)'(rv);
    sat_next = 1'b1;
    if (sum > AMAX) begin
      acc_next = AMAX[plac_pkg::ACC_WIDTH-1:0];
    end else if (sum < AMIN) begin
      acc_next = AMIN[plac_pkg::ACC_WIDTH-1:0];
    end else begin
      acc_next = sum[plac_pkg::ACC_WIDTH-1:0];
      sat_next = sat_seen;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rp     <= p_in;
      rt     <= t_in;
      rpc    <= pc;
      rompc  <= plac_pkg::ONE - pc;
      romt   <= plac_pkg::ONE - t_in;
      rd     <= p_in - t_in;
      last_r <= last_element;
    end
    if (cmd.start) begin
      kind_r <= cmd.uop.kind;
      dst_r  <= cmd.uop.dst;
    end
    if (stat.done) begin
      case (dst_r)
        plac_pkg::DST_RA: ra <= unit_res;
        plac_pkg::DST_RB: rb <= unit_res;
        plac_pkg::DST_RS: rs <= (unit_res < 64'sd1) ? 64'sd1 : unit_res;
        default:          ry <= unit_res;
      endcase
    end
    if (cmd.finish) begin
      rv <= v;
    end
    if (cmd.accum && last_r) begin
      result.loss_sum  <= 64'(acc_next);
      result.saturated <= sat_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc          <= '0;
      sat_seen     <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      if (result.valid && result.ready) begin
        result.valid <= 1'b0;
      end
      if (cmd.accum) begin
        if (last_r) begin
          acc          <= '0;
          sat_seen     <= 1'b0;
          result.valid <= 1'b1;
        end else begin
          acc      <= acc_next;
          sat_seen <= sat_next;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/plac_ctrl.sv */
`default_nettype none

// Sequencer: walks the micro-op list of the selected loss for each element.
module plac_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  plac_pkg::dp_stat_t stat,
  output plac_pkg::dp_cmd_t  cmd
);

  plac_pkg::ctrl_state_t state;
  plac_pkg::ctrl_state_t state_next;
  logic [2:0]            uidx;
  logic [2:0]            uidx_next;
  plac_pkg::uop_t        uop;
  logic                  out_blocked;

  assign uop         = plac_pkg::uop_lookup(stat.mode, uidx);
  assign out_blocked = stat.last && stat.out_valid;

  always_comb begin
    state_next = state;
    uidx_next  = uidx;
    case (state)
      plac_pkg::ST_IDLE: begin
        if (item_valid) begin
          state_next = plac_pkg::ST_ISSUE;
          uidx_next  = 3'd0;
        end
      end
      plac_pkg::ST_ISSUE: state_next = plac_pkg::ST_WAIT;
      plac_pkg::ST_WAIT: begin
        if (stat.done) begin
          if (uop.last) begin
            state_next = plac_pkg::ST_FINISH;
          end else begin
            state_next = plac_pkg::ST_ISSUE;
            uidx_next  = uidx + 3'd1;
          end
        end
      end
      plac_pkg::ST_FINISH: state_next = plac_pkg::ST_ACCUM;
      plac_pkg::ST_ACCUM: begin
        if (!out_blocked) begin
          state_next = plac_pkg::ST_IDLE;
        end
      end
      default: state_next = plac_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    item_ready = 1'b0;
    cmd        = '0;
    cmd.uop    = uop;
    case (state)
      plac_pkg::ST_IDLE: begin
        item_ready = 1'b1;
        cmd.load   = item_valid;
      end
      plac_pkg::ST_ISSUE:  cmd.start  = 1'b1;
      plac_pkg::ST_FINISH: cmd.finish = 1'b1;
      plac_pkg::ST_ACCUM:  cmd.accum  = !out_blocked;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= plac_pkg::ST_IDLE;
      uidx  <= 3'd0;
    end else begin
      state <= state_next;
      uidx  <= uidx_next;
    end
  end

endmodule

`default_nettype wire

/* tb/sv/plac_tb_pkg.sv */
package plac_tb_pkg;

  import plac_pkg::*;

  typedef logic signed [63:0] s64_t;

  typedef struct {
    s64_t loss_sum;
    logic saturated;
  } loss_result_t;

  // Bit-exact model of the loss datapath and the saturating sum.
  class loss_scoreboard;
    loss_mode_t   mode;
    s64_t         tol;
    s64_t         sig;
    s64_t         acc;
    logic         sat_seen;
    loss_result_t pending[$];
    int           errors;

    function void clear();
      mode     = MODE_XENT;
      tol      = 1;
      sig      = 65536;
      acc      = 0;
      sat_seen = 1'b0;
      pending.delete();
      errors   = 0;
    endfunction

    function void write_reg(reg_index_t idx, logic [31:0] val);
      case (idx)
        REG_LOSS_MODE: mode = loss_mode_t'(val[1:0]);
        REG_CLAMP_TOL: tol = s64_t'({49'd0, val[14:0]});
        REG_SIGMA:     sig = s64_t'({33'd0, val[30:0]});
        default: ;
      endcase
    endfunction

    static function s64_t sat_add(s64_t a, s64_t b);
      logic signed [64:0] s;
      s = 65'(a) + 65'(b);
      if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
      if (s < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
      return s[63:0];
    endfunction

    static function s64_t sat_neg(s64_t a);
      return (a == 64'sh8000_0000_0000_0000) ? 64'sh7FFF_FFFF_FFFF_FFFF : -a;
    endfunction

    // Product shifted right with magnitude truncation, saturated.
    static function s64_t mul_sh(s64_t a, s64_t b, int sh);
      logic [63:0]  ua, ub;
      logic [127:0] p;
      logic         neg;
      neg = (a < 0) != (b < 0);
      ua  = (a < 0) ? -a : a;
      ub  = (b < 0) ? -b : b;
      p   = ({64'd0, ua} * {64'd0, ub}) >> sh;
      if (neg) begin
        if (p > 128'h8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
        return -s64_t'(p[63:0]);
      end
      if (p > 128'h7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
      return s64_t'(p[63:0]);
    endfunction

    static function s64_t div_frac(s64_t a, s64_t b);
      logic [63:0] q;
      q = 64'(a) / 64'(b);
      if (q > (64'h7FFF_FFFF_FFFF_FFFF >> FRAC_BITS)) return 64'sh7FFF_FFFF_FFFF_FFFF;
      return s64_t'((80'(a) << FRAC_BITS) / 80'(b));
    endfunction

    static function s64_t nat_log(s64_t x);
      logic [63:0]  ux;
      logic [127:0] m;
      int           msb;
      s64_t         frac, y;
      ux   = (x < 1) ? 64'd1 : 64'(x);
      msb  = 63;
      frac = 0;
      while (msb > 0 && !ux[msb]) msb--;
      m = (msb >= 30) ? 128'(ux >> (msb - 30)) : 128'(ux << (30 - msb));
      for (int i = 0; i < LOG_ITERS; i++) begin
        m = (m * m) >> 30;
        if (m >= 128'h8000_0000) begin
          m = m >> 1;
          frac |= s64_t'(1) << (29 - i);
        end
      end
      y = s64_t'(msb - FRAC_BITS) * 64'sd1073741824 + frac;
      return mul_sh(y, LN2_Q30, 60 - FRAC_BITS);
    endfunction

    function s64_t elem_loss(s64_t p, s64_t t);
      s64_t one, d, v, s2, q, l, lo, hi;
      one = s64_t'(1) <<< FRAC_BITS;
      d   = p - t;
      case (mode)
        MODE_XENT: begin
          lo = tol;
          hi = one - tol;
          if (p > hi) p = hi;
          if (p < lo) p = lo;
          v = sat_add(mul_sh(t, nat_log(p), FRAC_BITS),
                      mul_sh(one - t, nat_log(one - p), FRAC_BITS));
          return sat_neg(v);
        end
        MODE_GAUSS: begin
          s2 = mul_sh(sig, sig, FRAC_BITS);
          if (s2 < 1) s2 = 1;
          q = div_frac(mul_sh(d, d, FRAC_BITS), s2);
          l = nat_log(mul_sh(s2, TWO_PI_Q30, 30));
          return sat_add(-(q / 2), -(l / 2));
        end
        MODE_BRIER: return mul_sh(d, d, FRAC_BITS);
        default: begin
          v = sat_add(one, sat_neg(mul_sh(t, p, FRAC_BITS)));
          return (v < 0) ? 0 : v;
        end
      endcase
    endfunction

    // Note an accepted item; queue the sum when it closes a vector.
    function void note_item(logic signed [31:0] p, logic signed [31:0] t, logic lst);
      s64_t         v;
      loss_result_t r;
      v = elem_loss(s64_t'(p), s64_t'(t));
      if ((v > 0 && acc > 64'sh7FFF_FFFF_FFFF_FFFF - v) ||
          (v < 0 && acc < 64'sh8000_0000_0000_0000 - v))
        sat_seen = 1'b1;
      acc = sat_add(acc, v);
      if (lst) begin
        r.loss_sum  = acc;
        r.saturated = sat_seen;
        pending.push_back(r);
        acc      = 0;
        sat_seen = 1'b0;
      end
    endfunction

    function void check_result(s64_t sum, logic sat);
      loss_result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result expected none actual sum=%0d sat=%0b",
                 $time, sum, sat);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (e.loss_sum !== sum) begin
        $display("%0t: loss_sum mismatch expected %0d actual %0d", $time, e.loss_sum, sum);
        errors++;
      end
      if (e.saturated !== sat) begin
        $display("%0t: saturated mismatch expected %0b actual %0b", $time, e.saturated, sat);
        errors++;
      end
    endfunction
  endclass

endpackage

/* tb/sv/tb_top.sv */
module tb_top;

  import plac_pkg::*;
  import plac_tb_pkg::*;

  localparam int IDLE_LIMIT = 20000;

  logic clk;
  logic rst;

  plac_cfg_if    cfg_ch ();
  plac_item_if   item_ch ();
  plac_result_if res_ch ();

  probabilistic_loss_accumulator dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch.sink),
    .item   (item_ch.sink),
    .result (res_ch.source)
  );

  loss_scoreboard sb;
  bit   quiet;       // last part of the run: no idling on either side
  bit   hold_off;    // receiver long stall request
  int   idle_cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Sample both channels on the edge; drivers update after it with NBAs.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (!rst && item_ch.valid && item_ch.ready)
      sb.note_item(item_ch.predicted, item_ch.target, item_ch.last_element);
    if (!rst && res_ch.valid && res_ch.ready)
      sb.check_result(res_ch.loss_sum, res_ch.saturated);
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver: random stall bursts, a long hold-off on request, none when quiet.
  initial begin
    int n;
    res_ch.ready = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_off) begin
        res_ch.ready <= 1'b0;
        repeat (1500) @(posedge clk);
        hold_off = 1'b0;
      end else if (!quiet && $urandom_range(3) == 0) begin
        n = $urandom_range(7, 1);
        res_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        res_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Send one item and hold it until accepted; maybe idle first.
  task automatic send_item(logic signed [31:0] p, logic signed [31:0] t, logic lst);
    int n;
    if (!quiet && $urandom_range(4) == 0) begin
      n = $urandom_range(7, 1);
      item_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    item_ch.valid        <= 1'b1;
    item_ch.predicted    <= p;
    item_ch.target       <= t;
    item_ch.last_element <= lst;
    do @(posedge clk); while (!item_ch.ready);
  endtask

  // Leave valid high; the caller drops it after the last write.
  task automatic write_reg(reg_index_t idx, logic [31:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.write_reg(idx, val);
  endtask

  // Drop valid, wait until every sum is back, then let the datapath drain.
  task automatic drain();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic set_mode(loss_mode_t m, logic [31:0] tol, logic [31:0] sg);
    drain();
    write_reg(REG_LOSS_MODE, 32'(m));
    write_reg(REG_CLAMP_TOL, tol);
    write_reg(REG_SIGMA, sg);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_val();
    case ($urandom_range(5))
      0: return $urandom();
      1: return 32'($urandom_range(65536));
      2: return $urandom_range(1) ? 32'h0001_0000 : 32'hFFFF_0000;
      3: return 32'(int'($urandom_range(400000)) - 200000);
      4: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($urandom_range(2000)) - 32'd1000;
    endcase
  endfunction

  initial begin
    logic [31:0] ext[4];
    logic [31:0] tols[4];
    logic [31:0] sigs[4];
    sb = new();
    sb.clear();
    quiet = 1'b0;
    hold_off = 1'b0;
    item_ch.valid = 1'b0;
    item_ch.predicted = '0;
    item_ch.target = '0;
    item_ch.last_element = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_LOSS_MODE;
    cfg_ch.data = '0;
    rst = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    ext  = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'h0001_0000};
    tols = '{32'd1, 32'd32767, 32'd40000, 32'hFFFF_8001};
    sigs = '{32'd1, 32'h7FFF_FFFF, 32'd65536, 32'hFFFF_FFFF};

    // Directed: every mode on field extremes; hinge labels; a brier vector with big sums.
    for (int m = 0; m < 4; m++) begin
      set_mode(loss_mode_t'(m), tols[m], sigs[m]);
      for (int k = 0; k < 4; k++)
        send_item(ext[k], ext[3 - k], k == 3);
      send_item(32'h0001_0000, 32'hFFFF_0000, 1'b1);
    end
    set_mode(MODE_BRIER, 1, 65536);
    for (int k = 0; k < 3; k++) send_item(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    for (int k = 0; k < 1; k++) send_item(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);

    // Random phases, one per register setting; long receiver stall in one.
    for (int ph = 0; ph < 12; ph++) begin
      set_mode(loss_mode_t'($urandom_range(3)),
               (ph % 3 == 0) ? 32'd1 : $urandom(),
               (ph % 4 == 0) ? 32'h7FFF_FFFF : (ph % 4 == 1) ? 32'd1 : $urandom());
      if (ph == 3) hold_off = 1'b1;
      if (ph == 11) quiet = 1'b1;
      for (int i = 0; i < 105; i++)
        send_item(rand_val(), rand_val(), $urandom_range(5) == 0 || i == 104);
    end

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
